// ----- rtl/core/normalized_legendre_evaluator_unit_assert.svh -----
// Assertion macros for the normalized Legendre evaluator
`ifndef NORMALIZED_LEGENDRE_EVALUATOR_UNIT_ASSERT_SVH
`define NORMALIZED_LEGENDRE_EVALUATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define NLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define NLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NLE_ASSERT(label, prop, msg)
`define NLE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/nle_pkg.sv -----
// Shared types, constants and coefficient tables of the Legendre evaluator
`default_nettype none

package nle_pkg;

    localparam int POS_W       = 32;
    localparam int ORDER_W     = 5;
    localparam int VAL_W       = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int MAX_ORDER   = 31;
    localparam int ROM_DEPTH   = 2 ** ORDER_W;

    localparam logic [ORDER_W-1:0] MAX_ORDER_CODE = ORDER_W'(MAX_ORDER);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DOMAIN_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOMAIN_MAX = 1'b1;

    localparam logic signed [POS_W-1:0] DOMAIN_MIN_RST = 32'sd0;
    localparam logic signed [POS_W-1:0] DOMAIN_MAX_RST = 32'sd65536;

    // 1.0 in Q2.30
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic [31:0]        Q31_U   = 32'h8000_0000;
    localparam logic [30:0]        Q30_U   = 31'h4000_0000;
    localparam logic [63:0]        Q30_64  = 64'd1073741824;

    typedef struct packed {
        logic signed [31:0]   z;
        logic [ORDER_W-1:0]   order;
        logic                 oor;
        logic                 bad;
    } nle_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } nle_qstat_t;

    // r(i) = ceil((2^30 - floor(i/2)) / i); c1 = 2^31 - r, c2 = 2^30 - r
    typedef logic [29:0] recip_rom_t [ROM_DEPTH];
    localparam recip_rom_t RECIP_ROM = '{
        30'd0,
        30'd0,
        30'((Q30_64 + 64'd0)  / 64'd2),
        30'((Q30_64 + 64'd1)  / 64'd3),
        30'((Q30_64 + 64'd1)  / 64'd4),
        30'((Q30_64 + 64'd2)  / 64'd5),
        30'((Q30_64 + 64'd2)  / 64'd6),
        30'((Q30_64 + 64'd3)  / 64'd7),
        30'((Q30_64 + 64'd3)  / 64'd8),
        30'((Q30_64 + 64'd4)  / 64'd9),
        30'((Q30_64 + 64'd4)  / 64'd10),
        30'((Q30_64 + 64'd5)  / 64'd11),
        30'((Q30_64 + 64'd5)  / 64'd12),
        30'((Q30_64 + 64'd6)  / 64'd13),
        30'((Q30_64 + 64'd6)  / 64'd14),
        30'((Q30_64 + 64'd7)  / 64'd15),
        30'((Q30_64 + 64'd7)  / 64'd16),
        30'((Q30_64 + 64'd8)  / 64'd17),
        30'((Q30_64 + 64'd8)  / 64'd18),
        30'((Q30_64 + 64'd9)  / 64'd19),
        30'((Q30_64 + 64'd9)  / 64'd20),
        30'((Q30_64 + 64'd10) / 64'd21),
        30'((Q30_64 + 64'd10) / 64'd22),
        30'((Q30_64 + 64'd11) / 64'd23),
        30'((Q30_64 + 64'd11) / 64'd24),
        30'((Q30_64 + 64'd12) / 64'd25),
        30'((Q30_64 + 64'd12) / 64'd26),
        30'((Q30_64 + 64'd13) / 64'd27),
        30'((Q30_64 + 64'd13) / 64'd28),
        30'((Q30_64 + 64'd14) / 64'd29),
        30'((Q30_64 + 64'd14) / 64'd30),
        30'((Q30_64 + 64'd15) / 64'd31)
    };

    // round(sqrt((2n+1)/2) * 2^28), bitwise integer square root with rounding
    function automatic logic [31:0] norm_factor(input int unsigned n);
        logic [63:0] x;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        x   = 64'(2 * n + 1) << 55;
        rem = x;
        res = '0;
        for (int k = 0; k < 32; k++)
        begin
            bit_v = 64'd1 << (62 - 2 * k);
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
        end
        if (x - res * res > res)
        begin
            res = res + 64'd1;
        end
        return res[31:0];
    endfunction

    typedef logic [31:0] norm_rom_t [ROM_DEPTH];

    function automatic norm_rom_t build_norm_rom();
        norm_rom_t rom;
        for (int n = 0; n < ROM_DEPTH; n++)
        begin
            rom[n] = norm_factor(n);
        end
        return rom;
    endfunction

    localparam norm_rom_t NORM_ROM = build_norm_rom();

endpackage

`default_nettype wire

// ----- rtl/core/nle_front.sv -----
// Front end: accepts a position, classifies it and maps it onto z by long division
`default_nettype none

module nle_front
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [nle_pkg::POS_W-1:0]           position,
    input  wire  [nle_pkg::ORDER_W-1:0]         order,
    input  wire  [nle_pkg::POS_W-1:0]           domain_min,
    input  wire  [nle_pkg::POS_W-1:0]           domain_max,
    output logic                                q_push,
    output nle_pkg::nle_item_t                  q_item,
    input  nle_pkg::nle_qstat_t                 q_stat
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CLASS = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    localparam logic [4:0] DIV_LAST = 5'd31;

    logic [1:0]                     state_reg, state_next;
    logic signed [32:0]             d_reg, d_next;
    logic signed [32:0]             dz_reg, dz_next;
    logic [nle_pkg::ORDER_W-1:0]    order_reg, order_next;
    logic [31:0]                    rem_reg, rem_next;
    logic [31:0]                    quo_reg, quo_next;
    logic [4:0]                     cnt_reg, cnt_next;
    nle_pkg::nle_item_t             item_reg, item_next;

    logic [32:0]                    dz_u;
    logic [32:0]                    rem_shift;
    logic [32:0]                    rem_sub;
    logic                           rem_ge;
    logic [nle_pkg::ORDER_W-1:0]    order_sat;

    assign dz_u      = dz_reg;
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_sub   = rem_shift - dz_u;
    assign rem_ge    = (rem_shift >= dz_u);
    assign order_sat = (order > nle_pkg::MAX_ORDER_CODE) ? nle_pkg::MAX_ORDER_CODE : order;

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        dz_next    = dz_reg;
        order_next = order_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    d_next     = $signed({position[31], position})
                               - $signed({domain_min[31], domain_min});
                    dz_next    = $signed({domain_max[31], domain_max})
                               - $signed({domain_min[31], domain_min});
                    order_next = order_sat;
                    state_next = F_CLASS;
                end
            end
            F_CLASS:
            begin
                item_next.order = order_reg;
                item_next.oor   = 1'b0;
                item_next.bad   = 1'b0;
                item_next.z     = '0;
                if (dz_reg <= 33'sd0)
                begin
                    item_next.bad = 1'b1;
                    state_next    = F_PUSH;
                end
                else if (d_reg < 33'sd0)
                begin
                    item_next.z   = -nle_pkg::ONE_Q30;
                    item_next.oor = 1'b1;
                    state_next    = F_PUSH;
                end
                else if (d_reg > dz_reg)
                begin
                    item_next.z   = nle_pkg::ONE_Q30;
                    item_next.oor = 1'b1;
                    state_next    = F_PUSH;
                end
                else
                begin
                    // dividend d*2^31 + floor(dz/2), upper word first
                    rem_next   = {1'b0, d_reg[31:1]};
                    quo_next   = {d_reg[0], dz_reg[31:1]};
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next = rem_ge ? rem_sub[31:0] : rem_shift[31:0];
                quo_next = {quo_reg[30:0], rem_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    item_next.z = $signed(quo_next - nle_pkg::ONE_Q30);
                    state_next  = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        dz_reg    <= dz_next;
        order_reg <= order_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        item_reg  <= item_next;
    end

    assign in_ready = (state_reg == F_IDLE);
    assign q_item   = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nle_queue.sv -----
// Small FIFO between the front end and the recurrence engine
`default_nettype none

module nle_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  nle_pkg::nle_item_t      push_item,
    input  wire                     pop,
    output nle_pkg::nle_item_t      pop_item,
    output nle_pkg::nle_qstat_t     stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nle_pkg::nle_item_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/core/nle_back.sv -----
// Back end: three-term recurrence on a shared multiplier, normalization, output register
`default_nettype none

module nle_back
(
    input  wire                             clk,
    input  wire                             rst_n,
    output logic                            q_pop,
    input  nle_pkg::nle_item_t              q_item,
    input  nle_pkg::nle_qstat_t             q_stat,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [nle_pkg::VAL_W-1:0]       out_value,
    output logic                            out_oor,
    output logic                            out_bad
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ZP   = 3'd1;
    localparam logic [2:0] B_ACC  = 3'd2;
    localparam logic [2:0] B_UPD  = 3'd3;
    localparam logic [2:0] B_NORM = 3'd4;
    localparam logic [2:0] B_FIN  = 3'd5;

    localparam logic [nle_pkg::ORDER_W-1:0] FIRST_STEP = nle_pkg::ORDER_W'(2);
    localparam logic [nle_pkg::ORDER_W-1:0] ONE_ORDER  = nle_pkg::ORDER_W'(1);

    localparam logic signed [65:0] RND_66   = 66'sd536870912;
    localparam logic signed [65:0] P_ONE_66 = 66'sd1073741824;
    localparam logic signed [65:0] N_ONE_66 = -66'sd1073741824;
    localparam logic signed [65:0] MAX_66   = 66'sd2147483647;
    localparam logic signed [65:0] MIN_66   = -66'sd2147483648;

    logic [2:0]                         state_reg, state_next;
    logic signed [31:0]                 z_reg, z_next;
    logic signed [31:0]                 pm1_reg, pm1_next;
    logic signed [31:0]                 pm2_reg, pm2_next;
    logic signed [31:0]                 zp_reg, zp_next;
    logic signed [62:0]                 tb_reg, tb_next;
    logic signed [65:0]                 acc_reg, acc_next;
    logic [31:0]                        a_reg, a_next;
    logic [29:0]                        b_reg, b_next;
    logic [nle_pkg::ORDER_W-1:0]        idx_reg, idx_next;
    logic [nle_pkg::ORDER_W-1:0]        order_reg, order_next;
    logic                               oor_reg, oor_next;
    logic                               bad_reg, bad_next;
    logic                               out_valid_reg, out_valid_next;
    logic [nle_pkg::VAL_W-1:0]          out_value_reg, out_value_next;
    logic                               out_oor_reg, out_oor_next;
    logic                               out_bad_reg, out_bad_next;

    logic signed [32:0]                 mul_a, mul_b;
    logic signed [65:0]                 prod_a;
    logic signed [62:0]                 prod_b;
    logic signed [65:0]                 zp_wide;
    logic signed [65:0]                 cur_wide;
    logic signed [31:0]                 cur_sat;
    logic signed [65:0]                 val_wide;
    logic [nle_pkg::VAL_W-1:0]          val_sat;
    logic [nle_pkg::ORDER_W-1:0]        coef_idx;
    logic [29:0]                        recip;

    // shared main multiplier
    always_comb
    begin
        mul_a = $signed({pm1_reg[31], pm1_reg});
        mul_b = $signed({z_reg[31], z_reg});
        case (state_reg)
            B_ACC:
            begin
                mul_a = $signed({zp_reg[31], zp_reg});
                mul_b = $signed({1'b0, a_reg});
            end
            B_NORM:
            begin
                mul_a = $signed({pm1_reg[31], pm1_reg});
                mul_b = $signed({1'b0, nle_pkg::NORM_ROM[order_reg]});
            end
            default:
            begin
                mul_a = $signed({pm1_reg[31], pm1_reg});
                mul_b = $signed({z_reg[31], z_reg});
            end
        endcase
    end

    assign prod_a  = mul_a * mul_b;
    assign prod_b  = $signed({1'b0, b_reg}) * pm2_reg;
    assign zp_wide = (prod_a + RND_66) >>> 30;

    // new P_i, clamped to [-1, 1]
    assign cur_wide = acc_reg >>> 30;
    always_comb
    begin
        if (cur_wide > P_ONE_66)
        begin
            cur_sat = nle_pkg::ONE_Q30;
        end
        else if (cur_wide < N_ONE_66)
        begin
            cur_sat = -nle_pkg::ONE_Q30;
        end
        else
        begin
            cur_sat = cur_wide[31:0];
        end
    end

    assign val_wide = acc_reg >>> 30;
    always_comb
    begin
        if (val_wide > MAX_66)
        begin
            val_sat = MAX_66[31:0];
        end
        else if (val_wide < MIN_66)
        begin
            val_sat = MIN_66[31:0];
        end
        else
        begin
            val_sat = val_wide[31:0];
        end
    end

    assign coef_idx = (state_reg == B_IDLE) ? FIRST_STEP : idx_reg + ONE_ORDER;
    assign recip    = nle_pkg::RECIP_ROM[coef_idx];

    always_comb
    begin
        state_next     = state_reg;
        z_next         = z_reg;
        pm1_next       = pm1_reg;
        pm2_next       = pm2_reg;
        zp_next        = zp_reg;
        tb_next        = tb_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        order_next     = order_reg;
        oor_next       = oor_reg;
        bad_next       = bad_reg;
        out_value_next = out_value_reg;
        out_oor_next   = out_oor_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    z_next     = q_item.z;
                    order_next = q_item.order;
                    oor_next   = q_item.oor;
                    bad_next   = q_item.bad;
                    pm2_next   = nle_pkg::ONE_Q30;
                    pm1_next   = (q_item.order == '0) ? nle_pkg::ONE_Q30 : q_item.z;
                    idx_next   = FIRST_STEP;
                    a_next     = nle_pkg::Q31_U - {2'b00, recip};
                    b_next     = 30'(nle_pkg::Q30_U - {1'b0, recip});
                    if (q_item.bad)
                    begin
                        state_next = B_FIN;
                    end
                    else if (q_item.order < FIRST_STEP)
                    begin
                        state_next = B_NORM;
                    end
                    else
                    begin
                        state_next = B_ZP;
                    end
                end
            end
            B_ZP:
            begin
                zp_next    = zp_wide[31:0];
                tb_next    = prod_b;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                acc_next   = prod_a - $signed({{3{tb_reg[62]}}, tb_reg}) + RND_66;
                state_next = B_UPD;
            end
            B_UPD:
            begin
                pm2_next = pm1_reg;
                pm1_next = cur_sat;
                if (idx_reg == order_reg)
                begin
                    state_next = B_NORM;
                end
                else
                begin
                    idx_next   = coef_idx;
                    a_next     = nle_pkg::Q31_U - {2'b00, recip};
                    b_next     = 30'(nle_pkg::Q30_U - {1'b0, recip});
                    state_next = B_ZP;
                end
            end
            B_NORM:
            begin
                acc_next   = prod_a + RND_66;
                state_next = B_FIN;
            end
            B_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = bad_reg ? '0 : val_sat;
                    out_oor_next   = oor_reg && !bad_reg;
                    out_bad_next   = bad_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        pm1_reg       <= pm1_next;
        pm2_reg       <= pm2_next;
        zp_reg        <= zp_next;
        tb_reg        <= tb_next;
        acc_reg       <= acc_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        idx_reg       <= idx_next;
        order_reg     <= order_next;
        oor_reg       <= oor_next;
        bad_reg       <= bad_next;
        out_value_reg <= out_value_next;
        out_oor_reg   <= out_oor_next;
        out_bad_reg   <= out_bad_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_oor   = out_oor_reg;
    assign out_bad   = out_bad_reg;

endmodule

`default_nettype wire

// ----- rtl/core/normalized_legendre_evaluator_unit.sv -----
// Top level of the orthonormal Legendre polynomial evaluator
//
//   channel   direction  transaction contents
//   s_axis    in         position Q16.16, order
//   m_axis    out        value Q4.28, out_of_range, bad_interval
//   cfg       in         domain_min / domain_max writes
//
// Front end: accept, classify, 32 restoring-division steps for a position in range, queue
// write (waits while the queue is full); a clamped position or an empty interval skips the
// division. Back end: B_ZP, B_ACC, B_UPD per recurrence step for order n >= 2, on a shared
// main multiplier and a P_(i-2) multiplier; orders 0, 1 and an empty interval skip the recurrence.
// Sustained rate is the slower of the two halves per item; the queue lets both halves overlap.
// Reset clears the control state and loads the interval [0, 1].
// A stalled m_axis holds the result; the back end then stops and the queue fills.
`default_nettype none

`include "normalized_legendre_evaluator_unit_assert.svh"

module normalized_legendre_evaluator_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [39:0]                         s_axis_tdata,   // position[31:0], order[36:32]
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // value[31:0]
    output logic [1:0]                          m_axis_tuser,   // out_of_range[0], bad_interval[1]
    input  wire                                 cfg_we,
    input  wire  [nle_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [31:0]                         cfg_data
);

    logic [nle_pkg::POS_W-1:0]  domain_min_reg, domain_min_next;
    logic [nle_pkg::POS_W-1:0]  domain_max_reg, domain_max_next;

    logic                       q_push;
    logic                       q_pop;
    nle_pkg::nle_item_t         q_push_item;
    nle_pkg::nle_item_t         q_pop_item;
    nle_pkg::nle_qstat_t        q_stat;

    logic                       res_oor;
    logic                       res_bad;

    always_comb
    begin
        domain_min_next = domain_min_reg;
        domain_max_next = domain_max_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                nle_pkg::CFG_DOMAIN_MIN: domain_min_next = cfg_data;
                nle_pkg::CFG_DOMAIN_MAX: domain_max_next = cfg_data;
                default:
                begin
                    domain_min_next = domain_min_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_min_reg <= nle_pkg::DOMAIN_MIN_RST;
            domain_max_reg <= nle_pkg::DOMAIN_MAX_RST;
        end
        else
        begin
            domain_min_reg <= domain_min_next;
            domain_max_reg <= domain_max_next;
        end
    end

    nle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .position   (s_axis_tdata[31:0]),
        .order      (s_axis_tdata[36:32]),
        .domain_min (domain_min_reg),
        .domain_max (domain_max_reg),
        .q_push     (q_push),
        .q_item     (q_push_item),
        .q_stat     (q_stat)
    );

    nle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (q_pop),
        .pop_item   (q_pop_item),
        .stat       (q_stat)
    );

    nle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_pop      (q_pop),
        .q_item     (q_pop_item),
        .q_stat     (q_stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (m_axis_tdata),
        .out_oor    (res_oor),
        .out_bad    (res_bad)
    );

    assign m_axis_tuser = {res_bad, res_oor};

    `NLE_ASSERT(a_bad_interval_zero, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]), "empty interval result not zero")
    `NLE_ASSERT(a_queue_no_overflow, q_push |-> !q_stat.full, "queue written while full")
    `NLE_ASSERT(a_queue_no_underflow, q_pop |-> !q_stat.empty, "queue read while empty")
    `NLE_ASSERT_NEXT(a_front_busy_after_accept, (s_axis_tvalid && s_axis_tready), !s_axis_tready, "front end ready right after a transaction")

endmodule

`default_nettype wire
